>>> design/fpba_pkg.sv
package fpba_pkg;

  localparam int OP_W     = 2;
  localparam int POL_W    = 2;
  localparam int STATUS_W = 2;
  localparam int BLK_W    = 4;
  localparam int IN_W     = 16;
  localparam int FREE_W   = 16;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_ALLOC  = 2'd2
  } op_e;

  typedef enum logic [POL_W-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } pol_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_WRITE
  } state_e;

  typedef struct packed {
    logic                vld;
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    blk;
    logic [FREE_W-1:0]   free;
  } res_t;

endpackage

>>> design/fpba_ram.sv
module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/fpba_ctrl.sv
module fpba_ctrl
  import fpba_pkg::*;
#(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [OP_W-1:0]               operation_i,
  input  logic [IN_W-1:0]               size_value_i,
  input  logic [POL_W-1:0]              policy_i,
  output logic                          busy_o,
  output res_t                          res_o,
  output logic                          we_o,
  output logic [$clog2(MAX_BLOCKS)-1:0] waddr_o,
  output logic [SIZE_WIDTH-1:0]         wdata_o,
  output logic [$clog2(MAX_BLOCKS)-1:0] raddr_o,
  input  logic [SIZE_WIDTH-1:0]         rdata_i
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [SIZE_WIDTH-1:0] sz_q, sz_d;
  logic [AW-1:0]         addr_q, addr_d;
  logic                  rd_pend_q, rd_pend_d;
  logic [AW-1:0]         rd_idx_q, rd_idx_d;
  logic                  found_q, found_d;
  logic [AW-1:0]         best_idx_q, best_idx_d;
  logic [SIZE_WIDTH-1:0] best_val_q, best_val_d;

  logic [SIZE_WIDTH-1:0] in_sz;
  logic [SIZE_WIDTH-1:0] new_free;
  logic                  fits;
  logic                  take;

  assign in_sz    = SIZE_WIDTH'(size_value_i);
  assign new_free = best_val_q - sz_q;
  assign fits     = (sz_q <= rdata_i);

  always_comb begin
    take = 1'b0;
    if (rd_pend_q && fits) begin
      if (!found_q) begin
        take = 1'b1;
      end else begin
        case (policy_i)
          POL_BEST:  take = (rdata_i < best_val_q);
          POL_WORST: take = (rdata_i > best_val_q);
          default:   take = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rd_pend_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_pend_q <= rd_pend_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sz_q       <= sz_d;
    addr_q     <= addr_d;
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    sz_d       = sz_q;
    addr_d     = addr_q;
    rd_pend_d  = 1'b0;
    rd_idx_d   = addr_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    res_o      = '0;
    we_o       = 1'b0;
    waddr_o    = count_q[AW-1:0];
    wdata_o    = in_sz;
    raddr_o    = addr_q;

    if (take) begin
      found_d    = 1'b1;
      best_idx_d = rd_idx_q;
      best_val_d = rdata_i;
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_o.vld = 1'b1;
          case (operation_i)
            OP_CLEAR: begin
              count_d      = '0;
              res_o.status = ST_CLEARED;
            end
            OP_APPEND: begin
              if (count_q >= CW'(MAX_BLOCKS)) begin
                res_o.status = ST_FULL;
              end else begin
                we_o         = 1'b1;
                count_d      = count_q + CW'(1);
                res_o.status = ST_DONE;
                res_o.blk    = BLK_W'(count_q);
                res_o.free   = FREE_W'(in_sz);
              end
            end
            OP_ALLOC: begin
              if (count_q == '0) begin
                res_o.status = ST_NOFIT;
              end else begin
                res_o.vld = 1'b0;
                sz_d      = in_sz;
                addr_d    = '0;
                found_d   = 1'b0;
                state_d   = S_SCAN;
              end
            end
            default: begin
              res_o.status = ST_NOFIT;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_pend_d = 1'b1;
        if (CW'(addr_q) == count_q - CW'(1)) begin
          state_d = S_DRAIN;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        state_d   = S_IDLE;
        res_o.vld = 1'b1;
        if (found_q) begin
          we_o         = 1'b1;
          waddr_o      = best_idx_q;
          wdata_o      = new_free;
          res_o.status = ST_DONE;
          res_o.blk    = BLK_W'(best_idx_q);
          res_o.free   = FREE_W'(new_free);
        end else begin
          res_o.status = ST_NOFIT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> design/fit_policy_block_allocator.sv
// Block allocator with first, best or worst fit over a table of up to
// MAX_BLOCKS free sizes held in one synchronous RAM. Clear and append
// transactions complete in the cycle they are taken, so start may be held
// high for them every cycle; their result strobes in the next cycle. An
// allocation reads the table entry by entry through the single RAM read
// port; busy covers the scan, drain and write states, the chosen entry is
// written back in the write state and the result strobes as busy falls.
// An allocation on an empty table completes like an append. Each result
// is shown for exactly one cycle and cannot be stalled. The user, not the
// block, must write fit_policy (cfg channel, always ready) while idle.
module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [IN_W-1:0]     size_value_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [POL_W-1:0]    cfg_data_i,
  output logic                result_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [BLK_W-1:0]    block_number_o,
  output logic [FREE_W-1:0]   free_after_o
);

  localparam int AW = $clog2(MAX_BLOCKS);

  logic [POL_W-1:0]      pol_q;
  res_t                  res_d;
  res_t                  res_q;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [SIZE_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [SIZE_WIDTH-1:0] rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q   <= POL_FIRST;
      res_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        pol_q <= cfg_data_i;
      end
      res_q <= res_d;
    end
  end

  fpba_ctrl #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .operation_i (operation_i),
    .size_value_i(size_value_i),
    .policy_i    (pol_q),
    .busy_o      (busy),
    .res_o       (res_d),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  fpba_ram #(
    .WIDTH(SIZE_WIDTH),
    .DEPTH(MAX_BLOCKS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign result_valid_o = res_q.vld;
  assign status_o       = res_q.status;
  assign block_number_o = res_q.blk;
  assign free_after_o   = res_q.free;

endmodule

>>> design/fpba_checker.sv
module fpba_checker
  import fpba_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic [OP_W-1:0]     operation_i,
  input logic                result_valid_o,
  input logic [STATUS_W-1:0] status_o,
  input logic [BLK_W-1:0]    block_number_o,
  input logic [FREE_W-1:0]   free_after_o
);

  // no result while an allocation scan is running
  a_no_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !result_valid_o)
    else $error("result strobed while busy");

  a_busy_from_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start) && ($past(operation_i) == OP_ALLOC))
    else $error("busy raised by a transaction other than allocate");

  a_result_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("allocation finished without a result");

  a_fail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != ST_DONE) |->
      (block_number_o == '0) && (free_after_o == '0))
    else $error("non-done result carries a block or size");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (.*);

>>> tb/sv/fit_policy_block_allocator_tb.sv
`timescale 1ns / 100ps

module fit_policy_block_allocator_tb;
  import fpba_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [IN_W-1:0] size;
    int              gap;
  } job_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    blk;
    logic [FREE_W-1:0]   free;
  } outcome_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic [OP_W-1:0]     operation_i    = '0;
  logic [IN_W-1:0]     size_value_i   = '0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [POL_W-1:0]    cfg_data_i     = '0;
  logic                result_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [BLK_W-1:0]    block_number_o;
  logic [FREE_W-1:0]   free_after_o;

  job_t     job_queue[$];
  outcome_t awaited_results[$];
  job_t     cur_job;
  bit       job_live = 1'b0;
  int       gap_left = 0;

  // allocator model
  logic [FREE_W-1:0] free_table[TABLE_DEPTH];
  logic [4:0]        block_total = '0;
  logic [POL_W-1:0]  policy_sel  = POL_FIRST;

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int phase_jobs     = 0;
  int calm_from_jobs = 0;
  bit calm_seq       = 1'b0;

  fit_policy_block_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .size_value_i  (size_value_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .block_number_o(block_number_o),
    .free_after_o  (free_after_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic apply_job(input job_t j);
    outcome_t o;
    bit       found;
    int       pick;
    o = '{status: ST_NOFIT, blk: '0, free: '0};
    found = 1'b0;
    pick = 0;
    case (j.op)
      OP_CLEAR: begin
        block_total = '0;
        o.status = ST_CLEARED;
      end
      OP_APPEND: begin
        if (block_total >= TABLE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          free_table[block_total[3:0]] = j.size;
          o = '{status: ST_DONE, blk: block_total[3:0], free: j.size};
          block_total = block_total + 5'd1;
        end
      end
      OP_ALLOC: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (i < block_total && j.size <= free_table[i]) begin
            if (!found) begin
              found = 1'b1;
              pick = i;
            end else if (policy_sel == POL_BEST && free_table[i] < free_table[pick]) begin
              pick = i;
            end else if (policy_sel == POL_WORST && free_table[i] > free_table[pick]) begin
              pick = i;
            end
          end
        end
        if (found) begin
          free_table[pick] = free_table[pick] - j.size;
          o = '{status: ST_DONE, blk: pick[3:0], free: free_table[pick]};
        end
      end
      default: ;
    endcase
    awaited_results.push_back(o);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic nxt_start;
    if (!rst_ni) begin
      start <= 1'b0;
      job_live = 1'b0;
      gap_left = 0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        apply_job(cur_job);
        job_live = 1'b0;
        nxt_start = 1'b0;
      end
      if (!job_live && job_queue.size() != 0) begin
        cur_job = job_queue.pop_front();
        job_live = 1'b1;
        gap_left = cur_job.gap;
      end
      if (job_live && !nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          nxt_start = 1'b1;
          operation_i <= cur_job.op;
          size_value_i <= cur_job.size;
        end
      end
      start <= nxt_start;
    end
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin : observe
    outcome_t e;
    if (rst_ni && result_valid_o) begin
      if (awaited_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result: status %0d block %0d free %0d",
                                status_o, block_number_o, free_after_o));
      end else begin
        e = awaited_results.pop_front();
        if (status_o !== e.status || block_number_o !== e.blk || free_after_o !== e.free)
          note_mismatch($sformatf(
            "mismatch: exp status %0d block %0d free %0d, got status %0d block %0d free %0d",
            e.status, e.blk, e.free, status_o, block_number_o, free_after_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_job(input logic [OP_W-1:0] op, input logic [IN_W-1:0] size);
    job_t j;
    j.op = op;
    j.size = size;
    if (calm_seq || phase_jobs >= calm_from_jobs || $urandom_range(0, 1) == 0)
      j.gap = 0;
    else
      j.gap = $urandom_range(1, 4);
    job_queue.push_back(j);
    phase_jobs++;
  endtask

  function automatic logic [IN_W-1:0] pick_size(input int mode);
    case (mode)
      0:       return IN_W'($urandom_range(0, 15));
      1:       return IN_W'($urandom_range(0, 2000));
      default: return IN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i);
    while (job_queue.size() != 0 || job_live || awaited_results.size() != 0);
  endtask

  task automatic write_policy(input logic [POL_W-1:0] pol);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= pol;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    policy_sel = pol;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input int count, input int calm_from);
    int mode;
    int appends;
    int tail;
    int r;
    phase_jobs = 0;
    calm_from_jobs = calm_from;
    while (phase_jobs < count) begin
      if ($urandom_range(0, 9) == 0) begin
        calm_seq = 1'b0;
        push_job(OP_W'($urandom_range(0, 3)), IN_W'($urandom));
      end else begin
        mode = $urandom_range(0, 2);
        calm_seq = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) != 0) push_job(OP_CLEAR, IN_W'($urandom));
        appends = $urandom_range(1, 17);
        for (int i = 0; i < appends; i++) push_job(OP_APPEND, pick_size(mode));
        tail = $urandom_range(4, 30);
        for (int i = 0; i < tail; i++) begin
          r = $urandom_range(0, 19);
          if (r < 14)      push_job(OP_ALLOC, pick_size(mode));
          else if (r < 17) push_job(OP_APPEND, pick_size(mode));
          else if (r < 18) push_job(2'd3, IN_W'($urandom));
          else             push_job(OP_CLEAR, IN_W'($urandom));
        end
      end
    end
    calm_seq = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, unused op, size extremes, zero-size request, full table
    calm_from_jobs = 1000;
    push_job(OP_ALLOC, 16'd0);
    push_job(OP_CLEAR, 16'hFFFF);
    push_job(2'd3, 16'h1234);
    push_job(OP_APPEND, 16'hFFFF);
    push_job(OP_APPEND, 16'h0000);
    push_job(OP_APPEND, 16'h8000);
    push_job(OP_ALLOC, 16'h0000);
    push_job(OP_ALLOC, 16'hFFFF);
    push_job(OP_ALLOC, 16'h0001);
    push_job(OP_ALLOC, 16'hFFFF);
    for (int i = 0; i < 13; i++) push_job(OP_APPEND, IN_W'(i * 37));
    push_job(OP_APPEND, 16'h5555);
    push_job(OP_ALLOC, 16'h7FFF);
    wait_drained();

    write_policy(POL_BEST);
    run_phase(305, 1000);
    write_policy(POL_WORST);
    run_phase(305, 1000);
    write_policy(2'd3);
    run_phase(305, 1000);
    write_policy(POL_FIRST);
    run_phase(305, 1000);
    write_policy(POL_WORST);
    run_phase(305, 1000);
    write_policy(POL_BEST);
    run_phase(305, 150);

    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
design/fpba_pkg.sv
design/fpba_ram.sv
design/fpba_ctrl.sv
design/fit_policy_block_allocator.sv
design/fpba_checker.sv
tb/sv/fit_policy_block_allocator_tb.sv
